@@ hdl/sipf_pkg.sv @@
// ----------------------------------------------------------------------------
// sipf_pkg
// Shared types, codes and frame builder for the servo instruction packet
// framer.
// ----------------------------------------------------------------------------
package sipf_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned FRAME_BYTES = 8;   // header through last parameter
  localparam int unsigned FRAME_W    = BYTE_W * FRAME_BYTES;
  localparam int unsigned IDX_W      = 4;

  localparam logic [BYTE_W-1:0] HDR_BYTE    = 8'hFF;
  localparam logic [BYTE_W-1:0] INSTR_WRITE = 8'h03;
  localparam logic [BYTE_W-1:0] INSTR_READ  = 8'h02;

  // Request modes
  localparam logic [1:0] MODE_BARE  = 2'd0;
  localparam logic [1:0] MODE_WRBYTE = 2'd1;
  localparam logic [1:0] MODE_WRWORD = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  // Index of the first byte that counts toward the checksum (servo id)
  localparam logic [IDX_W-1:0] SUM_FIRST_IDX = 4'd2;

  typedef struct packed {
    logic [FRAME_W-1:0] bytes;     // byte 0 in bits [7:0], sent first
    logic [IDX_W-1:0]   last_idx;  // index of the last byte before checksum
  } frame_t;

  typedef struct packed {
    logic sum_en;      // current head byte is part of the checksum
    logic final_byte;  // current head byte is the last before checksum
  } shreg_stat_t;

  function automatic frame_t build_frame(
    input logic [1:0]        mode,
    input logic [BYTE_W-1:0] servo_id,
    input logic [BYTE_W-1:0] instruction_code,
    input logic [BYTE_W-1:0] register_address,
    input logic [15:0]       write_value,
    input logic [BYTE_W-1:0] read_count
  );
    frame_t            f;
    logic [BYTE_W-1:0] instr;
    logic [BYTE_W-1:0] len;
    logic [BYTE_W-1:0] p0;
    logic [BYTE_W-1:0] p1;
    logic [BYTE_W-1:0] p2;
    logic [IDX_W-1:0]  last;
    p0 = '0;
    p1 = '0;
    p2 = '0;
    unique case (mode)
      MODE_BARE: begin
        instr = instruction_code;
        len   = 8'd2;
        last  = 4'd4;
      end
      MODE_WRBYTE: begin
        instr = INSTR_WRITE;
        len   = 8'd4;
        p0    = register_address;
        p1    = write_value[7:0];
        last  = 4'd6;
      end
      MODE_WRWORD: begin
        instr = INSTR_WRITE;
        len   = 8'd5;
        p0    = register_address;
        p1    = write_value[7:0];
        p2    = write_value[15:8];
        last  = 4'd7;
      end
      default: begin
        instr = INSTR_READ;
        len   = 8'd4;
        p0    = register_address;
        p1    = read_count;
        last  = 4'd6;
      end
    endcase
    f.bytes    = {p2, p1, p0, instr, len, servo_id, HDR_BYTE, HDR_BYTE};
    f.last_idx = last;
    return f;
  endfunction

endpackage

@@ hdl/sipf_shreg.sv @@
// ----------------------------------------------------------------------------
// sipf_shreg
// Byte-wide shift register holding the frame; presents one byte per step.
// ----------------------------------------------------------------------------
module sipf_shreg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  sipf_pkg::frame_t               frame,
  input  logic                           shift,
  output logic [sipf_pkg::BYTE_W-1:0]    head,
  output sipf_pkg::shreg_stat_t          stat
);

  logic [sipf_pkg::FRAME_W-1:0] data;
  logic [sipf_pkg::IDX_W-1:0]   idx;
  logic [sipf_pkg::IDX_W-1:0]   last_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (load) begin
      idx <= '0;
    end else if (shift) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data     <= frame.bytes;
      last_idx <= frame.last_idx;
    end else if (shift) begin
      // advance one byte toward the head
      data <= {{sipf_pkg::BYTE_W{1'b0}}, data[sipf_pkg::FRAME_W-1:sipf_pkg::BYTE_W]};
    end
  end

  assign head            = data[sipf_pkg::BYTE_W-1:0];
  assign stat.sum_en     = (idx >= sipf_pkg::SUM_FIRST_IDX);
  assign stat.final_byte = (idx == last_idx);

endmodule

@@ hdl/sipf_csum.sv @@
// ----------------------------------------------------------------------------
// sipf_csum
// Running 8-bit checksum accumulator, one byte per cycle while enabled.
// ----------------------------------------------------------------------------
module sipf_csum (
  input  logic                        clk,
  input  logic                        clr,
  input  logic                        en,
  input  logic [sipf_pkg::BYTE_W-1:0] din,
  output logic [sipf_pkg::BYTE_W-1:0] chk
);

  logic [sipf_pkg::BYTE_W-1:0] sum;

  always_ff @(posedge clk) begin
    if (clr) begin
      sum <= '0;
    end else if (en) begin
      sum <= sum + din;  // wraps modulo 256
    end
  end

  assign chk = ~sum;

endmodule

@@ hdl/servo_instruction_packet_framer_top.sv @@
// ----------------------------------------------------------------------------
// servo_instruction_packet_framer_top
// Frames one servo request into an instruction packet, one byte per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
//  Channel | Handshake            | Payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | mode, servo_id, instruction_code,
//          |                      | register_address, write_value, read_count
//  out     | out_valid / out_ready| packet_byte, last_byte
//
//  A request of N packet bytes (6, 8 or 9) first loads the frame shift register;
//  then, with no output stall, the bytes pass one per cycle through the byte
//  shifter and the checksum adder.
//  in_ready is high only between packets; the checksum byte may still sit in
//  the output register while the next request is taken.
//  Output stalls hold the shifter and accumulator in place.
//  rst is synchronous and clears the control state and the output valid.
// ----------------------------------------------------------------------------
module servo_instruction_packet_framer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [7:0]  servo_id,
  input  logic [7:0]  instruction_code,
  input  logic [7:0]  register_address,
  input  logic [15:0] write_value,
  input  logic [7:0]  read_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  packet_byte,
  output logic        last_byte
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SEND = 3'b010,
    ST_CHK  = 3'b100
  } state_t;

  state_t                      state;
  state_t                      state_next;
  logic                        accept;
  logic                        adv;
  logic                        send_step;
  sipf_pkg::frame_t            frame;
  logic [sipf_pkg::BYTE_W-1:0] head;
  sipf_pkg::shreg_stat_t       stat;
  logic [sipf_pkg::BYTE_W-1:0] chk;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign adv       = !out_valid || out_ready;
  assign send_step = (state == ST_SEND) && adv;

  assign frame = sipf_pkg::build_frame(mode, servo_id, instruction_code,
                                       register_address, write_value, read_count);

  sipf_shreg u_shreg (
    .clk   (clk),
    .rst   (rst),
    .load  (accept),
    .frame (frame),
    .shift (send_step),
    .head  (head),
    .stat  (stat)
  );

  sipf_csum u_csum (
    .clk (clk),
    .clr (accept),
    .en  (send_step && stat.sum_en),
    .din (head),
    .chk (chk)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_SEND;
      ST_SEND: if (adv && stat.final_byte) state_next = ST_CHK;
      ST_CHK:  if (adv) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (adv) begin
        out_valid <= (state == ST_SEND) || (state == ST_CHK);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (send_step) begin
      packet_byte <= head;
      last_byte   <= 1'b0;
    end else if ((state == ST_CHK) && adv) begin
      packet_byte <= chk;
      last_byte   <= 1'b1;
    end
  end

endmodule

@@ hdl/sipf_checker.sv @@
// ----------------------------------------------------------------------------
// sipf_checker
// Port-level checks for the servo instruction packet framer.
// ----------------------------------------------------------------------------
module sipf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  packet_byte,
  input logic        last_byte
);

  // a pending output transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(packet_byte) && $stable(last_byte))
    else $error("output payload changed while stalled");

  // a framed packet keeps the input closed on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a request was taken");

  // a pending byte ahead of the checksum keeps the input closed
  a_busy_while_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_byte |-> !in_ready)
    else $error("input ready while a packet byte is still pending");

  // between packets, nothing follows a delivered checksum on the next cycle
  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_byte && in_ready |=> !out_valid)
    else $error("output valid right after the last byte of a packet");

endmodule

bind servo_instruction_packet_framer_top sipf_checker u_sipf_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .packet_byte (packet_byte),
  .last_byte   (last_byte)
);

@@ tb/sv/servo_instruction_packet_framer_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// servo_instruction_packet_framer_top_tb
// Self-checking bench for the servo instruction packet framer. A table of
// directed requests and then random ones are sent into the request channel.
// Every packet byte that leaves the block is checked against a framing model
// held in the bench. Both channels idle and stall at random, with one long
// output hold-off and one pause that lets the block drain.
// ----------------------------------------------------------------------------
module servo_instruction_packet_framer_top_tb;

  localparam int unsigned CLK_HALF      = 4;
  localparam int unsigned RANDOM_ITEMS  = 82;
  localparam int unsigned GAP_PCT       = 14;
  localparam int unsigned HOLD_CYCLES   = 80;
  localparam int unsigned DRAIN_CYCLES  = 24;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam int unsigned DIRECTED_ROWS = 18;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  servo_id;
    logic [7:0]  instr_code;
    logic [7:0]  reg_addr;
    logic [15:0] wr_value;
    logic [7:0]  rd_count;
  } servo_request_t;

  typedef struct packed {
    servo_request_t req;
    logic           chk_known;  // checksum typed in below
    logic [7:0]     chk;
  } directed_row_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } packet_beat_t;

  // Rows with a typed checksum are simple enough to add up by hand.
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{'{sipf_pkg::MODE_BARE,   8'h00, 8'h00, 8'hFF, 16'hFFFF, 8'hFF}, 1'b1, 8'hFD},
    '{'{sipf_pkg::MODE_BARE,   8'hFF, 8'hFF, 8'h00, 16'h0000, 8'h00}, 1'b1, 8'hFF},
    '{'{sipf_pkg::MODE_BARE,   8'h01, 8'h01, 8'h12, 16'h3456, 8'h78}, 1'b0, 8'h00},
    '{'{sipf_pkg::MODE_BARE,   8'h7F, 8'h06, 8'h00, 16'h0000, 8'h00}, 1'b0, 8'h00},
    '{'{sipf_pkg::MODE_WRBYTE, 8'h01, 8'hFF, 8'h1E, 16'h0200, 8'hFF}, 1'b1, 8'hD9},
    '{'{sipf_pkg::MODE_WRBYTE, 8'hFF, 8'h00, 8'hFF, 16'h00FF, 8'h00}, 1'b1, 8'hFB},
    '{'{sipf_pkg::MODE_WRBYTE, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00}, 1'b1, 8'hF8},
    '{'{sipf_pkg::MODE_WRWORD, 8'h00, 8'hFF, 8'h00, 16'h0000, 8'hFF}, 1'b1, 8'hF7},
    '{'{sipf_pkg::MODE_WRWORD, 8'hFF, 8'h00, 8'hFF, 16'hFFFF, 8'h00}, 1'b1, 8'hFB},
    '{'{sipf_pkg::MODE_WRWORD, 8'h03, 8'h00, 8'h1E, 16'h03FF, 8'h00}, 1'b0, 8'h00},
    '{'{sipf_pkg::MODE_WRWORD, 8'h80, 8'h00, 8'h01, 16'h8001, 8'h00}, 1'b0, 8'h00},
    '{'{sipf_pkg::MODE_READ,   8'hFE, 8'h00, 8'h00, 16'h0000, 8'hFF}, 1'b1, 8'hFC},
    '{'{sipf_pkg::MODE_READ,   8'h01, 8'h00, 8'h2B, 16'h0000, 8'h01}, 1'b1, 8'hCC},
    '{'{sipf_pkg::MODE_READ,   8'h00, 8'hFF, 8'h00, 16'hFFFF, 8'h00}, 1'b1, 8'hF9},
    '{'{sipf_pkg::MODE_READ,   8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF}, 1'b0, 8'h00},
    '{'{sipf_pkg::MODE_BARE,   8'hFE, 8'h55, 8'hAA, 16'h55AA, 8'h55}, 1'b0, 8'h00},
    '{'{sipf_pkg::MODE_WRBYTE, 8'hAA, 8'hAA, 8'h55, 16'h55AA, 8'hAA}, 1'b0, 8'h00},
    '{'{sipf_pkg::MODE_READ,   8'h55, 8'h55, 8'hAA, 16'hAA55, 8'h80}, 1'b0, 8'h00}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  mode = '0;
  logic [7:0]  servo_id = '0;
  logic [7:0]  instruction_code = '0;
  logic [7:0]  register_address = '0;
  logic [15:0] write_value = '0;
  logic [7:0]  read_count = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  packet_byte;
  logic        last_byte;

  packet_beat_t pending_bytes [$];
  int unsigned  error_count = 0;
  int unsigned  quiet_cycles = 0;
  bit           gaps_on = 1'b1;
  bit           hold_off_req = 1'b0;

  servo_instruction_packet_framer_top dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .mode             (mode),
    .servo_id         (servo_id),
    .instruction_code (instruction_code),
    .register_address (register_address),
    .write_value      (write_value),
    .read_count       (read_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .packet_byte      (packet_byte),
    .last_byte        (last_byte)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  function automatic bit take_gap();
    return gaps_on && ($urandom_range(99) < GAP_PCT);
  endfunction

  // Frame one request and queue the packet bytes it should produce.
  function automatic void queue_packet(input servo_request_t r, input bit chk_known,
                                       input logic [7:0] chk_typed);
    logic [7:0] body [6];
    int         n;
    logic [7:0] sum;
    body[0] = r.servo_id;
    case (r.mode)
      sipf_pkg::MODE_BARE: begin
        body[2] = r.instr_code;
        n = 3;
      end
      sipf_pkg::MODE_WRBYTE: begin
        body[2] = sipf_pkg::INSTR_WRITE;
        body[3] = r.reg_addr;
        body[4] = r.wr_value[7:0];
        n = 5;
      end
      sipf_pkg::MODE_WRWORD: begin
        body[2] = sipf_pkg::INSTR_WRITE;
        body[3] = r.reg_addr;
        body[4] = r.wr_value[7:0];
        body[5] = r.wr_value[15:8];
        n = 6;
      end
      default: begin
        body[2] = sipf_pkg::INSTR_READ;
        body[3] = r.reg_addr;
        body[4] = r.rd_count;
        n = 5;
      end
    endcase
    // length is parameter count plus two
    body[1] = 8'(n - 1);
    pending_bytes.push_back('{sipf_pkg::HDR_BYTE, 1'b0});
    pending_bytes.push_back('{sipf_pkg::HDR_BYTE, 1'b0});
    sum = '0;
    for (int i = 0; i < n; i++) begin
      sum += body[i];
      pending_bytes.push_back('{body[i], 1'b0});
    end
    pending_bytes.push_back('{chk_known ? chk_typed : ~sum, 1'b1});
  endfunction

  function automatic servo_request_t random_request();
    servo_request_t r;
    r.mode       = 2'($urandom_range(3));
    r.servo_id   = 8'($urandom);
    r.instr_code = 8'($urandom);
    r.reg_addr   = 8'($urandom);
    r.wr_value   = 16'($urandom);
    r.rd_count   = 8'($urandom);
    return r;
  endfunction

  // Entered and left just after a falling edge.
  task automatic send_request(input servo_request_t r, input bit chk_known,
                              input logic [7:0] chk_typed);
    while (take_gap()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    mode             <= r.mode;
    servo_id         <= r.servo_id;
    instruction_code <= r.instr_code;
    register_address <= r.reg_addr;
    write_value      <= r.wr_value;
    read_count       <= r.rd_count;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    queue_packet(r, chk_known, chk_typed);
    @(negedge clk);
  endtask

  // Output side: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ready <= !take_gap();
      end
    end
  end

  always @(posedge clk) begin
    packet_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_bytes.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("unexpected packet byte %02h last %0b", packet_byte, last_byte);
      end else begin
        want = pending_bytes.pop_front();
        if (packet_byte !== want.value || last_byte !== want.last) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("packet byte mismatch: expected %02h last %0b, got %02h last %0b",
                     want.value, want.last, packet_byte, last_byte);
        end
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].chk_known, directed_rows[i].chk);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // hold the output while requests keep coming, so the input stalls
      if (n == 30) hold_off_req = 1'b1;
      // let the block drain completely before going on
      if (n == 50) begin
        while (pending_bytes.size() != 0) begin
          in_valid <= 1'b0;
          @(negedge clk);
        end
      end
      if (n == 55) gaps_on = 1'b0;
      if (n == 80) gaps_on = 1'b1;
      send_request(random_request(), 1'b0, 8'h00);
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_bytes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (error_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
